### rtl/core/srmt_pkg.sv
// Shared constants, command codes, states and store request type for the route match table.
package srmt_pkg;

  localparam int NUM_PIPES = 64;
  localparam int PIPE_W    = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
  localparam int SID_W     = 16;
  localparam int CH_W      = 8;
  localparam int KEY_W     = SID_W + CH_W;
  localparam int CMD_W     = 3;
  localparam int IDX_W     = 8;
  localparam int MASK_W    = 64;
  localparam int INST_W    = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP   = 3'd0,
    CMD_SET      = 3'd1,
    CMD_CLR_PIPE = 3'd2,
    CMD_CLR_SRC  = 3'd3,
    CMD_CLR_ALL  = 3'd4,
    CMD_INSTALL  = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic              wr_en;
    logic [PIPE_W-1:0] wr_addr;
    logic [KEY_W-1:0]  wr_data;
    logic              rd_en;
    logic [PIPE_W-1:0] rd_addr;
    logic              clr_en;
    logic [PIPE_W-1:0] clr_addr;
    logic              clr_all;
  } ks_req_t;

endpackage

### rtl/core/srmt_key_store.sv
// Route key memory with per-entry valid bits; an invalid entry reads as an empty key.
module srmt_key_store (
  input  logic                      clk,
  input  logic                      rst_n,
  input  srmt_pkg::ks_req_t         req,
  output logic [srmt_pkg::KEY_W-1:0] rd_key
);

  logic [srmt_pkg::KEY_W-1:0]   mem [srmt_pkg::NUM_PIPES];
  logic [srmt_pkg::NUM_PIPES-1:0] valid_r;
  logic [srmt_pkg::KEY_W-1:0]   rd_data_r;
  logic                         rd_valid_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (req.rd_en) begin
        rd_valid_r <= valid_r[req.rd_addr];
      end
      if (req.clr_all) begin
        valid_r <= '0;
      end else begin
        if (req.wr_en) begin
          valid_r[req.wr_addr] <= 1'b1;
        end
        if (req.clr_en) begin
          valid_r[req.clr_addr] <= 1'b0;
        end
      end
    end
  end

  assign rd_key = rd_valid_r ? rd_data_r : '0;

endmodule

### rtl/core/srmt_ctrl.sv
// Command sequencer: table scan, pipe enables and result registers.
module srmt_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [srmt_pkg::CMD_W-1:0]   in_cmd,
  input  logic [srmt_pkg::IDX_W-1:0]   in_pipe_index,
  input  logic [srmt_pkg::SID_W-1:0]   in_source_id,
  input  logic [srmt_pkg::CH_W-1:0]    in_source_channel,
  output srmt_pkg::ks_req_t            ks_req,
  input  logic [srmt_pkg::KEY_W-1:0]   rd_key,
  output logic                         out_valid,
  output logic [srmt_pkg::MASK_W-1:0]  out_match_mask,
  output logic [srmt_pkg::MASK_W-1:0]  out_free_map,
  output logic [srmt_pkg::INST_W-1:0]  out_install_index,
  output logic                         out_install_ok,
  output logic                         out_rejected
);

  srmt_pkg::state_t state_r, state_nxt;

  logic [srmt_pkg::CMD_W-1:0]     cmd_r, cmd_nxt;
  logic [srmt_pkg::IDX_W-1:0]     idx_r, idx_nxt;
  logic [srmt_pkg::KEY_W-1:0]     key_r, key_nxt;
  logic [srmt_pkg::PIPE_W-1:0]    scan_cnt_r, scan_cnt_nxt;
  logic                           cmp_vld_r, cmp_vld_nxt;
  logic [srmt_pkg::PIPE_W-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic [srmt_pkg::NUM_PIPES-1:0] match_r, match_nxt;
  logic                           found_r, found_nxt;
  logic [srmt_pkg::PIPE_W-1:0]    found_idx_r, found_idx_nxt;
  logic                           rej_r, rej_nxt;
  logic [srmt_pkg::NUM_PIPES-1:0] enable_r, enable_nxt;

  logic accept;
  logic sid_zero;
  logic idx_bad;
  logic scan_last;
  logic key_hit;

  assign busy      = !(state_r == srmt_pkg::ST_IDLE || state_r == srmt_pkg::ST_RESP);
  assign accept    = start && !busy;
  assign sid_zero  = (key_r[srmt_pkg::SID_W-1:0] == '0);
  assign idx_bad   = (idx_r >= srmt_pkg::IDX_W'(srmt_pkg::NUM_PIPES));
  assign scan_last = (scan_cnt_r == srmt_pkg::PIPE_W'(srmt_pkg::NUM_PIPES - 1));
  assign key_hit   = cmp_vld_r && (rd_key == key_r) && (key_r != '0);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      srmt_pkg::ST_IDLE: begin
        if (accept) state_nxt = srmt_pkg::ST_EXEC;
      end
      srmt_pkg::ST_EXEC: begin
        case (cmd_r)
          srmt_pkg::CMD_LOOKUP,
          srmt_pkg::CMD_INSTALL: state_nxt = srmt_pkg::ST_SCAN;
          srmt_pkg::CMD_CLR_SRC: state_nxt = sid_zero ? srmt_pkg::ST_RESP : srmt_pkg::ST_SCAN;
          default:               state_nxt = srmt_pkg::ST_RESP;
        endcase
      end
      srmt_pkg::ST_SCAN: begin
        if (scan_last) state_nxt = srmt_pkg::ST_DRAIN;
      end
      srmt_pkg::ST_DRAIN:  state_nxt = srmt_pkg::ST_FINISH;
      srmt_pkg::ST_FINISH: state_nxt = srmt_pkg::ST_RESP;
      srmt_pkg::ST_RESP: begin
        state_nxt = accept ? srmt_pkg::ST_EXEC : srmt_pkg::ST_IDLE;
      end
      default: state_nxt = srmt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ks_req    = '0;
    out_valid = (state_r == srmt_pkg::ST_RESP);
    case (state_r)
      srmt_pkg::ST_EXEC: begin
        case (cmd_r)
          srmt_pkg::CMD_SET: begin
            ks_req.wr_en   = !idx_bad && !sid_zero;
            ks_req.wr_addr = idx_r[srmt_pkg::PIPE_W-1:0];
            ks_req.wr_data = key_r;
          end
          srmt_pkg::CMD_CLR_PIPE: begin
            ks_req.clr_en   = !idx_bad;
            ks_req.clr_addr = idx_r[srmt_pkg::PIPE_W-1:0];
          end
          srmt_pkg::CMD_CLR_ALL: ks_req.clr_all = 1'b1;
          default: ;
        endcase
      end
      srmt_pkg::ST_SCAN, srmt_pkg::ST_DRAIN: begin
        ks_req.rd_en    = (state_r == srmt_pkg::ST_SCAN);
        ks_req.rd_addr  = scan_cnt_r;
        ks_req.clr_en   = (cmd_r == srmt_pkg::CMD_CLR_SRC) && key_hit;
        ks_req.clr_addr = cmp_idx_r;
      end
      srmt_pkg::ST_FINISH: begin
        ks_req.clr_en   = (cmd_r == srmt_pkg::CMD_INSTALL) && found_r;
        ks_req.clr_addr = found_idx_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    key_nxt       = key_r;
    scan_cnt_nxt  = scan_cnt_r;
    cmp_vld_nxt   = (state_r == srmt_pkg::ST_SCAN);
    cmp_idx_nxt   = scan_cnt_r;
    match_nxt     = match_r;
    found_nxt     = found_r;
    found_idx_nxt = found_idx_r;
    rej_nxt       = rej_r;
    enable_nxt    = enable_r;

    if (accept) begin
      cmd_nxt       = in_cmd;
      idx_nxt       = in_pipe_index;
      key_nxt       = {in_source_channel, in_source_id};
      scan_cnt_nxt  = '0;
      match_nxt     = '0;
      found_nxt     = 1'b0;
      found_idx_nxt = '0;
      rej_nxt       = 1'b0;
    end

    case (state_r)
      srmt_pkg::ST_EXEC: begin
        case (cmd_r)
          srmt_pkg::CMD_SET:      rej_nxt = idx_bad || sid_zero;
          srmt_pkg::CMD_CLR_PIPE: rej_nxt = idx_bad;
          srmt_pkg::CMD_CLR_SRC:  rej_nxt = sid_zero;
          default: ;
        endcase
      end
      srmt_pkg::ST_SCAN: begin
        scan_cnt_nxt = scan_cnt_r + 1'b1;
      end
      srmt_pkg::ST_FINISH: begin
        if (cmd_r == srmt_pkg::CMD_INSTALL && found_r) begin
          enable_nxt[found_idx_r] = 1'b1;
        end
      end
      default: ;
    endcase

    if (cmp_vld_r) begin
      if (cmd_r == srmt_pkg::CMD_LOOKUP && key_hit && enable_r[cmp_idx_r]) begin
        match_nxt[cmp_idx_r] = 1'b1;
      end
      if (cmd_r == srmt_pkg::CMD_INSTALL && !found_r && !enable_r[cmp_idx_r]) begin
        found_nxt     = 1'b1;
        found_idx_nxt = cmp_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srmt_pkg::ST_IDLE;
      cmp_vld_r   <= 1'b0;
      enable_r    <= '0;
      scan_cnt_r  <= '0;
      found_r     <= 1'b0;
      found_idx_r <= '0;
      rej_r       <= 1'b0;
      match_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      enable_r    <= enable_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      found_r     <= found_nxt;
      found_idx_r <= found_idx_nxt;
      rej_r       <= rej_nxt;
      match_r     <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    idx_r     <= idx_nxt;
    key_r     <= key_nxt;
    cmp_idx_r <= cmp_idx_nxt;
  end

  assign out_match_mask    = srmt_pkg::MASK_W'(match_r);
  assign out_free_map      = srmt_pkg::MASK_W'(~enable_r);
  assign out_install_index = srmt_pkg::INST_W'(found_idx_r);
  assign out_install_ok    = found_r;
  assign out_rejected      = rej_r;

endmodule

### rtl/core/source_route_match_table.sv
// Top level of the source route match table.
// Lookup, install and clear by a nonzero source pass through scan, drain and finish after execute,
// one key memory read per pipe; other commands go from execute straight to the result strobe.
// A new transaction is not accepted while busy, but is accepted in the cycle its predecessor's
// result is shown; the receiver cannot stall the one-cycle result.
// Reset: route keys read as empty and all pipes are disabled at once; no clearing pass.
module source_route_match_table (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [srmt_pkg::CMD_W-1:0]   in_cmd,
  input  logic [srmt_pkg::IDX_W-1:0]   in_pipe_index,
  input  logic [srmt_pkg::SID_W-1:0]   in_source_id,
  input  logic [srmt_pkg::CH_W-1:0]    in_source_channel,
  output logic                         out_valid,
  output logic [srmt_pkg::MASK_W-1:0]  out_match_mask,
  output logic [srmt_pkg::MASK_W-1:0]  out_free_map,
  output logic [srmt_pkg::INST_W-1:0]  out_install_index,
  output logic                         out_install_ok,
  output logic                         out_rejected
);

  srmt_pkg::ks_req_t          ks_req;
  logic [srmt_pkg::KEY_W-1:0] rd_key;

  srmt_key_store u_key_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (ks_req),
    .rd_key (rd_key)
  );

  srmt_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_pipe_index     (in_pipe_index),
    .in_source_id      (in_source_id),
    .in_source_channel (in_source_channel),
    .ks_req            (ks_req),
    .rd_key            (rd_key),
    .out_valid         (out_valid),
    .out_match_mask    (out_match_mask),
    .out_free_map      (out_free_map),
    .out_install_index (out_install_index),
    .out_install_ok    (out_install_ok),
    .out_rejected      (out_rejected)
  );

endmodule
